[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop on every rising clock edge outside reset.
`define SBAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check prop on every rising clock edge, reset included.
`define SBAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBAD_ASSERT(lbl, prop, msg)
`define SBAD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/sbad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbad_pkg
// Shared widths, reset values, register indexes and state codes of the
// spectrum bar averager.
// ----------------------------------------------------------------------------
package sbad_pkg;

  // Payload widths
  localparam int BIN_W      = 16;
  localparam int HEIGHT_W   = 16;
  localparam int BAR_IDX_W  = 4;
  localparam int BPB_W      = 9;
  localparam int MINH_W     = 15;
  localparam int MAXH_W     = 16;
  localparam int THR_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Significant bits of one bin sample
  localparam int SAMPLE_BITS = 16;

  // Defaults for the top-level parameters
  localparam int BAR_COUNT_DEF = 16;
  localparam int MAX_BINS_DEF  = 256;

  // Reset values
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 16'd819;
  localparam logic [BPB_W-1:0]    BPB_RESET      = 9'd16;
  localparam logic [MINH_W-1:0]   MINH_RESET     = 15'd819;
  localparam logic [MAXH_W-1:0]   MAXH_RESET     = 16'd16384;
  localparam logic [THR_W-1:0]    THR_RESET      = 15'd328;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINS_PER_BAR     = 2'd0,
    REG_MIN_HEIGHT       = 2'd1,
    REG_MAX_HEIGHT       = 2'd2,
    REG_CHANGE_THRESHOLD = 2'd3
  } cfg_reg_t;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_GATE = 2'd2
  } state_t;

endpackage

[src/sbad_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbad_channels
// Valid/ready channels: bin input, bar result and register writes.
// ----------------------------------------------------------------------------
interface sbad_bin_if
  import sbad_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  bin_value;
  logic              frame_start;
  modport source (output valid, output bin_value, output frame_start, input ready);
  modport sink   (input valid, input bin_value, input frame_start, output ready);
endinterface

interface sbad_bar_if
  import sbad_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [BAR_IDX_W-1:0] bar_index;
  logic [HEIGHT_W-1:0]  height;
  logic                 changed;
  modport source (output valid, output bar_index, output height, output changed,
                  input ready);
  modport sink   (input valid, input bar_index, input height, input changed,
                  output ready);
endinterface

interface sbad_cfg_if
  import sbad_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sbad_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbad_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbad_div #(
  parameter int DEND_W = 24,
  parameter int DSOR_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSOR_W-1:0] divisor,
  output logic              done,
  output logic [DEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DEND_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DSOR_W-1:0] dsor;
  logic [DSOR_W-1:0] rem;
  logic [DEND_W-1:0] quo;
  logic [DSOR_W:0]   shifted;
  logic [DSOR_W:0]   trial;
  logic              fits;
  logic [DSOR_W-1:0] rem_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    shifted  = {rem, quo[DEND_W-1]};
    trial    = shifted - {1'b0, dsor};
    fits     = ~trial[DSOR_W];
    rem_next = fits ? trial[DSOR_W-1:0] : shifted[DSOR_W-1:0];
  end

  // Step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      quo <= {quo[DEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

[src/spectrum_bar_averager_deadband.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bar_averager_deadband
// Averages runs of spectrum bins into bars and gates height updates with a
// deadband around the stored height of each bar.
// ----------------------------------------------------------------------------
// Usage:
//   bins    : one item per bin (bin_value, frame_start); frame_start marks bin 0
//             of bar 0 and restarts the bar and bin counts.
//   bars    : one item per completed bar (bar_index, height, changed).
//   cfg     : register writes (index, data), always ready; write while idle.
// Input flow: a bin that does not close a bar does not stall the input. A bin that
//   closes a bar runs the shared restoring divider, one quotient bit a cycle,
//   so input stalls through the divide and gate steps (ready only in ST_IDLE).
// Result path: closing bin -> ST_DIV (divide) -> ST_GATE -> output register.
// Heights live in a BAR_COUNT-entry memory with registered read; per-entry
//   valid bits make unwritten bars read as the reset height, so no clearing
//   pass is needed after reset.
// Reset: registers take their defaults, counters clear, all heights read 819.
// Stall: while a result waits, bins keep being taken; the next closing bar
//   holds in the gate step until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_bar_averager_deadband
  import sbad_pkg::*;
#(
  parameter int BAR_COUNT        = BAR_COUNT_DEF,
  parameter int MAX_BINS_PER_BAR = MAX_BINS_DEF
) (
  input  logic clk,
  input  logic rst,
  sbad_bin_if.sink   in_ch,
  sbad_bar_if.source out_ch,
  sbad_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(MAX_BINS_PER_BAR + 1);
  localparam int ACC_W = BIN_W + CNT_W;
  localparam int BAR_W = $clog2(BAR_COUNT + 1);
  localparam int IDX_W = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
  localparam int EFF_W = (CNT_W > BPB_W) ? CNT_W : BPB_W;
  localparam logic [BIN_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= BIN_W) ? {BIN_W{1'b1}} : BIN_W'((1 << SAMPLE_BITS) - 1);

  // Configuration registers
  logic [BPB_W-1:0]  bins_per_bar;
  logic [MINH_W-1:0] min_height;
  logic [MAXH_W-1:0] max_height;
  logic [THR_W-1:0]  change_threshold;

  // Accumulation state
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] bin_cnt;
  logic [BAR_W-1:0] bar_cnt;
  state_t           state;
  state_t           state_next;

  // Height store
  logic [HEIGHT_W-1:0]  mem [BAR_COUNT];
  logic [HEIGHT_W-1:0]  rd_data;
  logic [BAR_COUNT-1:0] hvalid;
  logic [IDX_W-1:0]     idx;

  // Output register
  logic                 out_valid;
  logic [BAR_IDX_W-1:0] out_index;
  logic [HEIGHT_W-1:0]  out_height;
  logic                 out_changed;

  // Datapath signals
  logic                 in_ready;
  logic                 accept;
  logic                 gate_fire;
  logic [EFF_W-1:0]     bpb_ext;
  logic [EFF_W-1:0]     n_full;
  logic [CNT_W-1:0]     n_eff;
  logic [BIN_W-1:0]     sample;
  logic [BAR_W-1:0]     bar_base;
  logic [ACC_W-1:0]     acc_base;
  logic [CNT_W-1:0]     cnt_base;
  logic [ACC_W-1:0]     acc_sum;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 overrun;
  logic                 bar_close;
  logic                 div_done;
  logic [ACC_W-1:0]     quotient;
  logic [ACC_W-1:0]     h_lo;
  logic [ACC_W-1:0]     h_clamp;
  logic [HEIGHT_W-1:0]  h;
  logic [HEIGHT_W-1:0]  old_h;
  logic [HEIGHT_W-1:0]  diff;
  logic                 chg;
  logic [BAR_W+BAR_IDX_W-1:0] bar_wide;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_per_bar     <= BPB_RESET;
      min_height       <= MINH_RESET;
      max_height       <= MAXH_RESET;
      change_threshold <= THR_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_BINS_PER_BAR:     bins_per_bar     <= cfg.data[BPB_W-1:0];
        REG_MIN_HEIGHT:       min_height       <= cfg.data[MINH_W-1:0];
        REG_MAX_HEIGHT:       max_height       <= cfg.data[MAXH_W-1:0];
        REG_CHANGE_THRESHOLD: change_threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bins per bar: zero acts as one, clip to the maximum
  always_comb begin
    bpb_ext = EFF_W'(bins_per_bar);
    if (bins_per_bar == '0) begin
      n_full = EFF_W'(1);
    end else if (bpb_ext > EFF_W'(MAX_BINS_PER_BAR)) begin
      n_full = EFF_W'(MAX_BINS_PER_BAR);
    end else begin
      n_full = bpb_ext;
    end
    n_eff = n_full[CNT_W-1:0];
  end

  // Take one bin into the running bar
  always_comb begin
    sample    = in_ch.bin_value & SAMPLE_MASK;
    bar_base  = in_ch.frame_start ? '0 : bar_cnt;
    acc_base  = in_ch.frame_start ? '0 : acc;
    cnt_base  = in_ch.frame_start ? '0 : bin_cnt;
    acc_sum   = acc_base + ACC_W'(sample);
    cnt_inc   = cnt_base + 1'b1;
    overrun   = (bar_base >= BAR_W'(BAR_COUNT));
    bar_close = !overrun && (cnt_inc >= n_eff);
  end

  assign accept = in_ch.valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && bar_close) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_GATE;
      ST_GATE: if (gate_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    gate_fire = (state == ST_GATE) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      bin_cnt <= '0;
      bar_cnt <= '0;
    end else if (accept) begin
      bar_cnt <= bar_base;
      if (overrun) begin
        acc     <= acc_base;
        bin_cnt <= cnt_base;
      end else if (bar_close) begin
        acc     <= '0;
        bin_cnt <= '0;
      end else begin
        acc     <= acc_sum;
        bin_cnt <= cnt_inc;
      end
    end else if (gate_fire) begin
      bar_cnt <= bar_cnt + 1'b1;
    end
  end

  // Mean of the closed bar
  sbad_div #(
    .DEND_W (ACC_W),
    .DSOR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && bar_close),
    .dividend (acc_sum),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Height store: read the current bar every cycle, write on update
  assign idx = bar_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (gate_fire && chg) begin
      mem[idx] <= h;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else if (gate_fire && chg) begin
      hvalid[idx] <= 1'b1;
    end
  end

  // Clamp, then compare against the stored height
  always_comb begin
    h_lo    = (quotient < ACC_W'(min_height)) ? ACC_W'(min_height) : quotient;
    h_clamp = (h_lo > ACC_W'(max_height)) ? ACC_W'(max_height) : h_lo;
    h       = h_clamp[HEIGHT_W-1:0];
    old_h   = hvalid[idx] ? rd_data : HEIGHT_RESET;
    diff    = (h > old_h) ? (h - old_h) : (old_h - h);
    chg     = (diff > HEIGHT_W'(change_threshold));
    bar_wide = {{BAR_IDX_W{1'b0}}, bar_cnt};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gate_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gate_fire) begin
      out_index   <= bar_wide[BAR_IDX_W-1:0];
      out_height  <= chg ? h : old_h;
      out_changed <= chg;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.bar_index = out_index;
  assign out_ch.height    = out_height;
  assign out_ch.changed   = out_changed;
  assign in_ch.ready      = in_ready;

  // Assertions
  `SBAD_ASSERT(a_done_in_div, div_done |-> (state == ST_DIV), "divider done outside ST_DIV")
  `SBAD_ASSERT(a_close_starts_div, (accept && bar_close) |=> (state == ST_DIV),
               "closing bin did not start the divider")
  `SBAD_ASSERT(a_result_from_gate, $rose(out_valid) |-> $past(state == ST_GATE),
               "result appeared without a gate step")
  `SBAD_ASSERT(a_gate_in_range, (state == ST_GATE) |-> (bar_cnt < BAR_W'(BAR_COUNT)),
               "gate step on a bar past the last one")

endmodule
